// ===== sv/gtp_pkg.sv =====
// Shared types, constants and helper function of the go-to-point velocity command block.
// No dependencies; every other file of the block imports it.
package gtp_pkg;

  localparam int COORD_WIDTH_DEF = 16;
  localparam int ANGLE_WIDTH_DEF = 16;

  localparam int SPEED_W = 16;
  localparam int VEL_W   = 17;
  localparam int KICK_W  = 10;
  localparam int ID_W    = 4;
  localparam int CNT_W   = 5;

  localparam int ZW             = 33;
  localparam int PRESCALE_SH    = 8;
  localparam int GUARD_BITS     = 3;
  localparam int CORDIC_STEPS   = 28;
  localparam int ROT_PER_STAGE  = 4;
  localparam int ROT_STAGES     = CORDIC_STEPS / ROT_PER_STAGE;
  localparam int SQRT_STEPS     = 16;
  localparam int SQRT_PER_STAGE = 2;
  localparam int DIV_BITS       = 16;
  localparam int DIV_PER_STAGE  = 2;
  localparam int DIV_STAGES     = DIV_BITS / DIV_PER_STAGE;

  localparam logic [16:0]        NEAR_R2   = 17'd625;
  localparam logic [16:0]        TAPER_R2  = 17'd40000;
  localparam logic [15:0]        TAPER_DEN = 16'd51200;
  localparam logic [7:0]         FAR_LIMIT = 8'd200;
  localparam logic [KICK_W-1:0]  KICK_Q88  = 10'd512;

  typedef enum logic {
    CFG_BLUE_COUNT   = 1'b0,
    CFG_YELLOW_COUNT = 1'b1
  } cfg_reg_t;

  typedef logic [31:0] angle32_t;

  localparam angle32_t ATAN_TURN32 [CORDIC_STEPS] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
    32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
    32'h00000014, 32'h0000000A, 32'h00000005
  };

  typedef struct packed {
    logic [SPEED_W-1:0] speed;
    logic               kick;
    logic               blue;
    logic [ID_W-1:0]    id;
    logic               move;
    logic               taper;
  } gtp_side_t;

  typedef struct packed {
    gtp_side_t side;
    logic      sx;
    logic      sy;
    logic      ezero;
  } gtp_ctrl_t;

  typedef struct packed {
    logic [31:0] rem;
    logic [31:0] res;
  } sqrt_state_t;

  function automatic sqrt_state_t sqrt_step(sqrt_state_t s, int k);
    sqrt_state_t o;
    logic [31:0] bit_v;
    logic [32:0] trial;
    bit_v = 32'd1 << (30 - 2 * k);
    trial = {1'b0, s.res} + {1'b0, bit_v};
    if ({1'b0, s.rem} >= trial) begin
      o.rem = s.rem - trial[31:0];
      o.res = (s.res >> 1) + bit_v;
    end else begin
      o.rem = s.rem;
      o.res = s.res >> 1;
    end
    return o;
  endfunction

endpackage

// ===== sv/go_to_point_velocity_command.sv =====
// Go-to-point velocity command: takes one command request per cycle unless the output stalls
// and returns the robot-frame velocity through 2 front, 7 rotation, 3 scale, 8 divide and 1
// output stage. The pipeline moves only while the output register is empty or being taken,
// so a stalled result holds every stage. Requests whose id exceeds the team count yield nothing.
module go_to_point_velocity_command import gtp_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF,
  parameter int ANGLE_WIDTH = ANGLE_WIDTH_DEF,
  localparam int IN_BITS   = 4 * COORD_WIDTH + ANGLE_WIDTH + SPEED_W + 1 + ID_W,
  localparam int IN_TDATA_W = ((IN_BITS + 7) / 8) * 8,
  localparam int OUT_BITS  = 2 * VEL_W + KICK_W + ID_W,
  localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // robot_x, robot_y, target_x, target_y, heading, speed, kick_request, robot_id
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // is_blue
  input  logic                   in_tuser,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // vel_tangent, vel_normal, kick_speed, command_robot_id
  output logic [OUT_TDATA_W-1:0] out_tdata,
  // team_yellow
  output logic                   out_tuser,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic                   cfg_index,
  input  logic [CNT_W-1:0]       cfg_data
);

  localparam int CW = COORD_WIDTH;
  localparam int AW = ANGLE_WIDTH;
  localparam int XW = CW + 1 + PRESCALE_SH + GUARD_BITS - 1;
  localparam int NW = XW + 32;
  localparam int DW = XW + 16;
  localparam int P_HEAD  = 4 * CW;
  localparam int P_SPEED = P_HEAD + AW;
  localparam int P_KICK  = P_SPEED + SPEED_W;
  localparam int P_ID    = P_KICK + 1;

  logic             en;
  logic [CNT_W-1:0] blue_cnt_r, yellow_cnt_r;

  logic                 rv [0:ROT_STAGES];
  gtp_side_t            rs [0:ROT_STAGES];
  logic signed [XW-1:0] rx [0:ROT_STAGES];
  logic signed [XW-1:0] ry [0:ROT_STAGES];
  logic signed [ZW-1:0] rz [0:ROT_STAGES];
  sqrt_state_t          rq [0:ROT_STAGES];

  logic                dv [0:DIV_STAGES];
  gtp_ctrl_t           dc [0:DIV_STAGES];
  logic [NW-1:0]       drx [0:DIV_STAGES];
  logic [NW-1:0]       dry [0:DIV_STAGES];
  logic [DIV_BITS-1:0] dqx [0:DIV_STAGES];
  logic [DIV_BITS-1:0] dqy [0:DIV_STAGES];
  logic [DW-1:0]       dd [0:DIV_STAGES];

  logic                   out_tvalid_r;
  logic [OUT_TDATA_W-1:0] out_tdata_r, out_tdata_nxt;
  logic                   out_tuser_r;
  logic [VEL_W-1:0]       vt, vn;
  gtp_ctrl_t              cf;

  assign en        = !out_tvalid_r || out_tready;
  assign in_tready = en;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blue_cnt_r   <= '0;
      yellow_cnt_r <= '0;
    end else if (cfg_valid) begin
      case (cfg_reg_t'(cfg_index))
        CFG_BLUE_COUNT:   blue_cnt_r   <= cfg_data;
        CFG_YELLOW_COUNT: yellow_cnt_r <= cfg_data;
        default: ;
      endcase
    end
  end

  gtp_front #(.CW(CW), .AW(AW), .XW(XW)) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .en           (en),
    .accept       (in_tvalid && in_tready),
    .robot_x      (in_tdata[CW-1:0]),
    .robot_y      (in_tdata[2*CW-1:CW]),
    .target_x     (in_tdata[3*CW-1:2*CW]),
    .target_y     (in_tdata[4*CW-1:3*CW]),
    .heading      (in_tdata[P_SPEED-1:P_HEAD]),
    .speed        (in_tdata[P_KICK-1:P_SPEED]),
    .kick_request (in_tdata[P_KICK]),
    .is_blue      (in_tuser),
    .robot_id     (in_tdata[P_ID+ID_W-1:P_ID]),
    .blue_count   (blue_cnt_r),
    .yellow_count (yellow_cnt_r),
    .valid_o      (rv[0]),
    .side_o       (rs[0]),
    .x_o          (rx[0]),
    .y_o          (ry[0]),
    .z_o          (rz[0]),
    .sq_o         (rq[0])
  );

  for (genvar s = 0; s < ROT_STAGES; s++) begin : g_rot
    gtp_rot_stage #(
      .XW       (XW),
      .FIRST    (s * ROT_PER_STAGE),
      .SQ_FIRST (s * SQRT_PER_STAGE)
    ) u_rot (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (en),
      .valid_i (rv[s]),
      .side_i  (rs[s]),
      .x_i     (rx[s]),
      .y_i     (ry[s]),
      .z_i     (rz[s]),
      .sq_i    (rq[s]),
      .valid_o (rv[s+1]),
      .side_o  (rs[s+1]),
      .x_o     (rx[s+1]),
      .y_o     (ry[s+1]),
      .z_o     (rz[s+1]),
      .sq_o    (rq[s+1])
    );
  end

  gtp_scale #(.XW(XW), .NW(NW), .DW(DW)) u_scale (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .valid_i (rv[ROT_STAGES]),
    .side_i  (rs[ROT_STAGES]),
    .x_i     (rx[ROT_STAGES]),
    .y_i     (ry[ROT_STAGES]),
    .sq_i    (rq[ROT_STAGES]),
    .valid_o (dv[0]),
    .ctrl_o  (dc[0]),
    .nx_o    (drx[0]),
    .ny_o    (dry[0]),
    .d_o     (dd[0])
  );

  assign dqx[0] = '0;
  assign dqy[0] = '0;

  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_div
    gtp_div_stage #(.NW(NW), .DW(DW), .FIRST(s * DIV_PER_STAGE)) u_div (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (en),
      .valid_i (dv[s]),
      .ctrl_i  (dc[s]),
      .remx_i  (drx[s]),
      .remy_i  (dry[s]),
      .qx_i    (dqx[s]),
      .qy_i    (dqy[s]),
      .d_i     (dd[s]),
      .valid_o (dv[s+1]),
      .ctrl_o  (dc[s+1]),
      .remx_o  (drx[s+1]),
      .remy_o  (dry[s+1]),
      .qx_o    (dqx[s+1]),
      .qy_o    (dqy[s+1]),
      .d_o     (dd[s+1])
    );
  end

  always_comb begin
    cf = dc[DIV_STAGES];
    vt = cf.sx ? VEL_W'(-{1'b0, dqx[DIV_STAGES]}) : VEL_W'({1'b0, dqx[DIV_STAGES]});
    vn = cf.sy ? VEL_W'(-{1'b0, dqy[DIV_STAGES]}) : VEL_W'({1'b0, dqy[DIV_STAGES]});
    if (!cf.side.move || cf.ezero) begin
      vt = '0;
      vn = '0;
    end
    out_tdata_nxt = OUT_TDATA_W'({cf.side.id, (cf.side.kick ? KICK_Q88 : KICK_W'(0)), vn, vt});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (en) begin
      out_tvalid_r <= dv[DIV_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_tdata_r <= out_tdata_nxt;
      out_tuser_r <= !cf.side.blue;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

`ifndef SYNTHESIS
  a_kick_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[2*VEL_W+KICK_W-1:2*VEL_W] == KICK_Q88 ||
                    out_tdata[2*VEL_W+KICK_W-1:2*VEL_W] == KICK_W'(0)))
    else $error("kick speed field is neither zero nor the kick value");

  a_vel_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[VEL_W-1:0] != {1'b1, {(VEL_W-1){1'b0}}} &&
                    out_tdata[2*VEL_W-1:VEL_W] != {1'b1, {(VEL_W-1){1'b0}}}))
    else $error("velocity magnitude exceeds the speed range");

  a_scale_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (dv[0] && dc[0].side.move) |-> !dc[0].ezero)
    else $error("rotated offset collapsed to zero for a moving command");
`endif

endmodule

// ===== sv/gtp_front.sv =====
// Front stages: team filter, offset, squared range, range class and half-turn pre-rotation.
// Depends on gtp_pkg.
module gtp_front import gtp_pkg::*; #(
  parameter int CW = COORD_WIDTH_DEF,
  parameter int AW = ANGLE_WIDTH_DEF,
  parameter int XW = COORD_WIDTH_DEF + 1 + PRESCALE_SH + GUARD_BITS - 1
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 accept,
  input  logic signed [CW-1:0] robot_x,
  input  logic signed [CW-1:0] robot_y,
  input  logic signed [CW-1:0] target_x,
  input  logic signed [CW-1:0] target_y,
  input  logic [AW-1:0]        heading,
  input  logic [SPEED_W-1:0]   speed,
  input  logic                 kick_request,
  input  logic                 is_blue,
  input  logic [ID_W-1:0]      robot_id,
  input  logic [CNT_W-1:0]     blue_count,
  input  logic [CNT_W-1:0]     yellow_count,
  output logic                 valid_o,
  output gtp_side_t            side_o,
  output logic signed [XW-1:0] x_o,
  output logic signed [XW-1:0] y_o,
  output logic signed [ZW-1:0] z_o,
  output sqrt_state_t          sq_o
);

  logic                 va_r;
  logic signed [CW:0]   dx_r, dy_r, dx_nxt, dy_nxt;
  logic [16:0]          r2_r, r2_nxt;
  logic                 big_r, big_nxt;
  logic [AW-1:0]        heading_r;
  gtp_side_t            sa_r, sa_nxt;
  logic [CW:0]          dx_abs, dy_abs;
  logic signed [8:0]    dx9, dy9;
  logic signed [17:0]   sqx, sqy;
  logic [CNT_W-1:0]     limit;

  logic                 vb_r;
  gtp_side_t            sb_r, sb_nxt;
  logic signed [XW-1:0] xb_r, yb_r, xb_nxt, yb_nxt;
  logic signed [ZW-1:0] zb_r, zb_nxt;
  sqrt_state_t          sqb_r, sqb_nxt;
  logic [31:0]          ang;
  logic                 flip;

  always_comb begin
    limit  = is_blue ? blue_count : yellow_count;
    dx_nxt = (CW + 1)'(target_x) - (CW + 1)'(robot_x);
    dy_nxt = (CW + 1)'(target_y) - (CW + 1)'(robot_y);
    dx_abs = dx_nxt[CW] ? (CW + 1)'(-dx_nxt) : dx_nxt;
    dy_abs = dy_nxt[CW] ? (CW + 1)'(-dy_nxt) : dy_nxt;
    big_nxt = (dx_abs >= (CW + 1)'(FAR_LIMIT)) || (dy_abs >= (CW + 1)'(FAR_LIMIT));
    dx9 = dx_nxt[8:0];
    dy9 = dy_nxt[8:0];
    sqx = dx9 * dx9;
    sqy = dy9 * dy9;
    r2_nxt = sqx[16:0] + sqy[16:0];
    sa_nxt = '{speed: speed, kick: kick_request, blue: is_blue, id: robot_id,
               move: 1'b0, taper: 1'b0};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
    end else if (en) begin
      va_r <= accept && ({1'b0, robot_id} <= limit);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dx_r      <= dx_nxt;
      dy_r      <= dy_nxt;
      r2_r      <= r2_nxt;
      big_r     <= big_nxt;
      heading_r <= heading;
      sa_r      <= sa_nxt;
    end
  end

  always_comb begin
    sb_nxt       = sa_r;
    sb_nxt.move  = big_r || (r2_r > NEAR_R2);
    sb_nxt.taper = !big_r && (r2_r > NEAR_R2) && (r2_r < TAPER_R2);
    ang  = 32'd0 - {heading_r, {(32 - AW){1'b0}}};
    flip = ang[31] ^ ang[30];
    xb_nxt = {{(XW - CW - 1 - PRESCALE_SH){dx_r[CW]}}, dx_r, {PRESCALE_SH{1'b0}}};
    yb_nxt = {{(XW - CW - 1 - PRESCALE_SH){dy_r[CW]}}, dy_r, {PRESCALE_SH{1'b0}}};
    if (flip) begin
      xb_nxt = -xb_nxt;
      yb_nxt = -yb_nxt;
      ang[31] = ~ang[31];
    end
    zb_nxt = {ang[31], ang};
    sqb_nxt.rem = {r2_r[15:0], 16'd0};
    sqb_nxt.res = 32'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vb_r <= 1'b0;
    end else if (en) begin
      vb_r <= va_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sb_r  <= sb_nxt;
      xb_r  <= xb_nxt;
      yb_r  <= yb_nxt;
      zb_r  <= zb_nxt;
      sqb_r <= sqb_nxt;
    end
  end

  assign valid_o = vb_r;
  assign side_o  = sb_r;
  assign x_o     = xb_r;
  assign y_o     = yb_r;
  assign z_o     = zb_r;
  assign sq_o    = sqb_r;

endmodule

// ===== sv/gtp_rot_stage.sv =====
// One rotation stage: four vectoring-free CORDIC rotation steps plus two range square-root steps.
// Depends on gtp_pkg.
module gtp_rot_stage import gtp_pkg::*; #(
  parameter int XW       = COORD_WIDTH_DEF + 1 + PRESCALE_SH + GUARD_BITS - 1,
  parameter int FIRST    = 0,
  parameter int SQ_FIRST = 0
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 valid_i,
  input  gtp_side_t            side_i,
  input  logic signed [XW-1:0] x_i,
  input  logic signed [XW-1:0] y_i,
  input  logic signed [ZW-1:0] z_i,
  input  sqrt_state_t          sq_i,
  output logic                 valid_o,
  output gtp_side_t            side_o,
  output logic signed [XW-1:0] x_o,
  output logic signed [XW-1:0] y_o,
  output logic signed [ZW-1:0] z_o,
  output sqrt_state_t          sq_o
);

  logic                 valid_r;
  gtp_side_t            side_r;
  logic signed [XW-1:0] x_r, y_r, x_nxt, y_nxt;
  logic signed [ZW-1:0] z_r, z_nxt;
  sqrt_state_t          sq_r, sq_nxt;

  always_comb begin
    logic signed [XW-1:0] xs;
    logic signed [XW-1:0] ys;
    x_nxt  = x_i;
    y_nxt  = y_i;
    z_nxt  = z_i;
    sq_nxt = sq_i;
    for (int i = 0; i < ROT_PER_STAGE; i++) begin
      xs = x_nxt >>> (FIRST + i);
      ys = y_nxt >>> (FIRST + i);
      if (!z_nxt[ZW-1]) begin
        x_nxt = x_nxt - ys;
        y_nxt = y_nxt + xs;
        z_nxt = z_nxt - $signed({1'b0, ATAN_TURN32[FIRST + i]});
      end else begin
        x_nxt = x_nxt + ys;
        y_nxt = y_nxt - xs;
        z_nxt = z_nxt + $signed({1'b0, ATAN_TURN32[FIRST + i]});
      end
    end
    for (int j = 0; j < SQRT_PER_STAGE; j++) begin
      sq_nxt = sqrt_step(sq_nxt, SQ_FIRST + j);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_r <= side_i;
      x_r    <= x_nxt;
      y_r    <= y_nxt;
      z_r    <= z_nxt;
      sq_r   <= sq_nxt;
    end
  end

  assign valid_o = valid_r;
  assign side_o  = side_r;
  assign x_o     = x_r;
  assign y_o     = y_r;
  assign z_o     = z_r;
  assign sq_o    = sq_r;

endmodule

// ===== sv/gtp_scale.sv =====
// Scale stages: magnitudes, larger component, last root steps, then numerator and divisor products.
// Depends on gtp_pkg.
module gtp_scale import gtp_pkg::*; #(
  parameter int XW = COORD_WIDTH_DEF + 1 + PRESCALE_SH + GUARD_BITS - 1,
  parameter int NW = XW + 32,
  parameter int DW = XW + 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 valid_i,
  input  gtp_side_t            side_i,
  input  logic signed [XW-1:0] x_i,
  input  logic signed [XW-1:0] y_i,
  input  sqrt_state_t          sq_i,
  output logic                 valid_o,
  output gtp_ctrl_t            ctrl_o,
  output logic [NW-1:0]        nx_o,
  output logic [NW-1:0]        ny_o,
  output logic [DW-1:0]        d_o
);

  logic          v0_r, v1_r, v2_r;
  gtp_ctrl_t     c0_r, c1_r, c2_r, c0_nxt;
  logic [XW-1:0] ax_r, ay_r, e_r, ax_nxt, ay_nxt, e_nxt;
  logic [15:0]   r8_r;
  sqrt_state_t   sq_fin;
  logic [DW-1:0] px_r, py_r, d1_r, px_nxt, py_nxt, d1_nxt;
  logic [15:0]   m_r, m_nxt;
  logic [NW-1:0] nx_r, ny_r, nx_nxt, ny_nxt;
  logic [DW-1:0] d2_r;

  always_comb begin
    ax_nxt = x_i[XW-1] ? XW'(-x_i) : XW'(x_i);
    ay_nxt = y_i[XW-1] ? XW'(-y_i) : XW'(y_i);
    e_nxt  = (ax_nxt > ay_nxt) ? ax_nxt : ay_nxt;
    sq_fin = sq_i;
    for (int j = 0; j < SQRT_PER_STAGE; j++) begin
      sq_fin = sqrt_step(sq_fin, SQRT_STEPS - SQRT_PER_STAGE + j);
    end
    c0_nxt.side  = side_i;
    c0_nxt.sx    = x_i[XW-1];
    c0_nxt.sy    = y_i[XW-1];
    c0_nxt.ezero = (e_nxt == '0);
  end

  always_comb begin
    px_nxt = DW'(ax_r) * DW'(c0_r.side.speed);
    py_nxt = DW'(ay_r) * DW'(c0_r.side.speed);
    d1_nxt = DW'(e_r) * DW'(TAPER_DEN);
    m_nxt  = c0_r.side.taper ? r8_r : TAPER_DEN;
  end

  always_comb begin
    nx_nxt = NW'(px_r) * NW'(m_r);
    ny_nxt = NW'(py_r) * NW'(m_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (en) begin
      v0_r <= valid_i;
      v1_r <= v0_r;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c0_r <= c0_nxt;
      ax_r <= ax_nxt;
      ay_r <= ay_nxt;
      e_r  <= e_nxt;
      r8_r <= sq_fin.res[15:0];
      c1_r <= c0_r;
      px_r <= px_nxt;
      py_r <= py_nxt;
      d1_r <= d1_nxt;
      m_r  <= m_nxt;
      c2_r <= c1_r;
      nx_r <= nx_nxt;
      ny_r <= ny_nxt;
      d2_r <= d1_r;
    end
  end

  assign valid_o = v2_r;
  assign ctrl_o  = c2_r;
  assign nx_o    = nx_r;
  assign ny_o    = ny_r;
  assign d_o     = d2_r;

endmodule

// ===== sv/gtp_div_stage.sv =====
// One divider stage: two restoring quotient bits for both velocity components, shared divisor.
// Depends on gtp_pkg.
module gtp_div_stage import gtp_pkg::*; #(
  parameter int NW    = COORD_WIDTH_DEF + 1 + PRESCALE_SH + GUARD_BITS - 1 + 32,
  parameter int DW    = COORD_WIDTH_DEF + 1 + PRESCALE_SH + GUARD_BITS - 1 + 16,
  parameter int FIRST = 0
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                valid_i,
  input  gtp_ctrl_t           ctrl_i,
  input  logic [NW-1:0]       remx_i,
  input  logic [NW-1:0]       remy_i,
  input  logic [DIV_BITS-1:0] qx_i,
  input  logic [DIV_BITS-1:0] qy_i,
  input  logic [DW-1:0]       d_i,
  output logic                valid_o,
  output gtp_ctrl_t           ctrl_o,
  output logic [NW-1:0]       remx_o,
  output logic [NW-1:0]       remy_o,
  output logic [DIV_BITS-1:0] qx_o,
  output logic [DIV_BITS-1:0] qy_o,
  output logic [DW-1:0]       d_o
);

  logic                valid_r;
  gtp_ctrl_t           ctrl_r;
  logic [NW-1:0]       remx_r, remy_r, remx_nxt, remy_nxt;
  logic [DIV_BITS-1:0] qx_r, qy_r, qx_nxt, qy_nxt;
  logic [DW-1:0]       d_r;

  always_comb begin
    logic [NW-1:0] sh;
    logic          bx;
    logic          by;
    remx_nxt = remx_i;
    remy_nxt = remy_i;
    qx_nxt   = qx_i;
    qy_nxt   = qy_i;
    for (int j = 0; j < DIV_PER_STAGE; j++) begin
      sh = NW'(d_i) << (DIV_BITS - 1 - FIRST - j);
      bx = (remx_nxt >= sh);
      by = (remy_nxt >= sh);
      if (bx) remx_nxt = remx_nxt - sh;
      if (by) remy_nxt = remy_nxt - sh;
      qx_nxt = {qx_nxt[DIV_BITS-2:0], bx};
      qy_nxt = {qy_nxt[DIV_BITS-2:0], by};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctrl_r <= ctrl_i;
      remx_r <= remx_nxt;
      remy_r <= remy_nxt;
      qx_r   <= qx_nxt;
      qy_r   <= qy_nxt;
      d_r    <= d_i;
    end
  end

  assign valid_o = valid_r;
  assign ctrl_o  = ctrl_r;
  assign remx_o  = remx_r;
  assign remy_o  = remy_r;
  assign qx_o    = qx_r;
  assign qy_o    = qy_r;
  assign d_o     = d_r;

endmodule
